@@ rtl/core/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer files.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int IDX_W = 11;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h0A;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] cell_index;
    } cmd_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] cursor_cell;
        logic             scrolled;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_READ
    } tcw_state_t;

endpackage

@@ rtl/core/tcw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/text_console_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine over a COLUMNS x ROWS cell RAM (char + attribute).
//
//  channel | signals                         | payload
//  --------+---------------------------------+-----------------------------
//  cmd     | cmd_valid / cmd_ready           | cmd  (opcode, char, index)
//  rsp     | rsp_valid / rsp_ready           | rsp  (cursor, scrolled, cell)
//  cfg     | cfg_valid / cfg_ready           | cfg_data (text attribute)
//
// Put, CR, LF, null and unused opcode: result registered at accept.
// Read: accept moves to ST_READ, which registers the RAM read data into rsp.
// Scroll and clear: one cell per cycle through the single RAM write port;
// cmd_ready stays low meanwhile.
// After reset a clearing pass blanks the RAM with cmd_ready low; cfg writes
// are taken at any time.
// A stalled rsp holds cmd_ready low unless the rsp item leaves that cycle.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int ROWW  = $clog2(ROWS);

    tcw_state_t      state_reg, state_next;
    logic [AW-1:0]   cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [ROWW-1:0] row_reg, row_next;
    logic [7:0]      attr_reg;
    logic [7:0]      walk_attr_reg, walk_attr_next;
    logic            walk_scroll_reg, walk_scroll_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            wr_pend_reg, wr_pend_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic            wr_move_reg, wr_move_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_reg, rsp_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [15:0]     ram_rdata;

    logic                 accept;
    logic [AW+IDX_W-1:0]  cur_ext;
    logic [AW+IDX_W-1:0]  idx_ext;
    logic                 idx_ok;
    logic                 last_col;
    logic                 last_row;

    function automatic logic [IDX_W-1:0] cursor_cell_of(input logic [AW-1:0] c);
        logic [AW+IDX_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, c};
        return wide[IDX_W-1:0];
    endfunction

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready = (state_reg == ST_IDLE) && !wr_pend_reg
                       && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cur_ext  = {{IDX_W{1'b0}}, cursor_reg};
    assign idx_ext  = {{AW{1'b0}}, cmd.cell_index};
    assign idx_ok   = 32'(cmd.cell_index) < CELLS;
    assign last_col = col_reg == COLW'(COLUMNS - 1);
    assign last_row = row_reg == ROWW'(ROWS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cursor_reg      <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            attr_reg        <= RESET_ATTR;
            walk_attr_reg   <= RESET_ATTR;
            walk_scroll_reg <= 1'b0;
            ptr_reg         <= '0;
            wr_pend_reg     <= 1'b0;
            wr_move_reg     <= 1'b0;
            rd_ok_reg       <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            walk_attr_reg   <= walk_attr_next;
            walk_scroll_reg <= walk_scroll_next;
            ptr_reg         <= ptr_next;
            wr_pend_reg     <= wr_pend_next;
            wr_move_reg     <= wr_move_next;
            rd_ok_reg       <= rd_ok_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        walk_attr_next   = walk_attr_reg;
        walk_scroll_next = walk_scroll_reg;
        ptr_next         = ptr_reg;
        wr_pend_next     = 1'b0;
        wr_addr_next     = wr_addr_reg;
        wr_move_next     = 1'b0;
        rd_ok_next       = rd_ok_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;

        // pending walk write owns the port; cmd_ready keeps puts away from it
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = wr_move_reg ? ram_rdata : {walk_attr_reg, CHAR_BLANK};
        ram_raddr = idx_ext[AW-1:0];

        case (state_reg)
            ST_INIT, ST_WALK:
            begin
                // stage: read source row below, write it in the following cycle
                wr_pend_next = 1'b1;
                wr_addr_next = ptr_reg;
                wr_move_next = walk_scroll_reg && (ptr_reg < AW'(CELLS - COLUMNS));
                ram_raddr    = ptr_reg + AW'(COLUMNS);
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.scrolled    = 1'b0;
                    rsp_next.read_char   = '0;
                    rsp_next.read_attr   = '0;
                    case (cmd.opcode)
                        OP_PUT:
                        begin
                            if (cmd.char_code == CHAR_LF)
                            begin
                                if (last_row)
                                begin
                                    rsp_next.scrolled = 1'b1;
                                end
                                else
                                begin
                                    row_next    = row_reg + ROWW'(1);
                                    col_next    = '0;
                                    cursor_next = cursor_reg - AW'(col_reg) + AW'(COLUMNS);
                                end
                            end
                            else if (cmd.char_code == CHAR_CR)
                            begin
                                col_next    = '0;
                                cursor_next = cursor_reg - AW'(col_reg);
                            end
                            else if (cmd.char_code != CHAR_NUL)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_reg;
                                ram_wdata = {attr_reg, cmd.char_code};
                                if (last_col)
                                begin
                                    if (last_row)
                                    begin
                                        rsp_next.scrolled = 1'b1;
                                    end
                                    else
                                    begin
                                        row_next    = row_reg + ROWW'(1);
                                        col_next    = '0;
                                        cursor_next = cursor_reg + AW'(1);
                                    end
                                end
                                else
                                begin
                                    col_next    = col_reg + COLW'(1);
                                    cursor_next = cursor_reg + AW'(1);
                                end
                            end
                            if (rsp_next.scrolled)
                            begin
                                row_next         = ROWW'(ROWS - 1);
                                col_next         = '0;
                                cursor_next      = AW'(CELLS - COLUMNS);
                                walk_scroll_next = 1'b1;
                                walk_attr_next   = attr_reg;
                                ptr_next         = '0;
                                state_next       = ST_WALK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_next         = '0;
                            col_next         = '0;
                            cursor_next      = '0;
                            walk_scroll_next = 1'b0;
                            walk_attr_next   = attr_reg;
                            ptr_next         = '0;
                            state_next       = ST_WALK;
                        end
                        OP_READ:
                        begin
                            rsp_valid_next = 1'b0;
                            rd_ok_next     = idx_ok;
                            state_next     = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.cursor_cell = cursor_cell_of(cursor_next);
                end
            end
            ST_READ:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.cursor_cell = cur_ext[IDX_W-1:0];
                rsp_next.scrolled    = 1'b0;
                rsp_next.read_char   = rd_ok_reg ? ram_rdata[7:0]  : 8'h00;
                rsp_next.read_attr   = rd_ok_reg ? ram_rdata[15:8] : 8'h00;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cursor, row and column agree and stay on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg)
        && 32'(col_reg) < COLUMNS && 32'(row_reg) < ROWS)
    else $error("cursor out of step with row and column");

    // a read waits for the RAM with the response register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !rsp_valid_reg)
    else $error("read result would overwrite a pending item");

    // last walk step returns to idle with the final write still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK || state_reg == ST_INIT) && ptr_reg == AW'(CELLS - 1)
        |=> state_reg == ST_IDLE && wr_pend_reg && !cmd_ready)
    else $error("walk did not drain correctly");

    // a scroll report leaves the cursor at the start of the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.scrolled
        |-> cursor_reg == AW'(CELLS - COLUMNS))
    else $error("scroll reported with cursor off the last row");

endmodule
